// ===== rtl/crc8_frame_checker_macros.svh =====
// Assertion macros shared by the frame checker RTL.
// Needs clk and rst in scope at the place of use.
`ifndef CRC8_FRAME_CHECKER_MACROS_SVH
`define CRC8_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, idle during reset.
`define CRC8FC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, idle during reset.
`define CRC8FC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// ===== rtl/crc8fc_pkg.sv =====
// Shared constants, types and the CRC-8 byte step of the frame checker.
// No dependencies.
package crc8fc_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'hD8;
  localparam logic [7:0]  START_CH0 = 8'h45;
  localparam logic [7:0]  START_CH1 = 8'h4D;
  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_NEED     = 2'd1;
  localparam logic [1:0] ST_HDR_BAD  = 2'd2;
  localparam logic [1:0] ST_PAY_BAD  = 2'd3;

  // Frame state after the current beat, as seen by the verdict logic.
  typedef struct packed {
    logic [15:0] count;
    logic        start_ok;
    logic        header_crc_ok;
    logic [15:0] frame_length;
    logic [7:0]  body_crc;
    logic [7:0]  expected_crc;
  } frame_snap_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) r = (r << 1) ^ CRC_POLY;
      else      r = r << 1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/crc8_frame_checker.sv =====
// Top level of the CRC-8 framed packet checker.
// Depends on crc8fc_pkg, crc8fc_in_reg, crc8fc_tracker and crc8fc_verdict.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   in      | in_valid / in_stall  | byte_value[7:0], last_byte
//   out     | out_valid / out_stall| status[1:0], amount[16:0]
//
// One byte beat per cycle sustained while no stalled result holds the input register.
// A verdict's out_valid rises once its last byte has passed the input register, then the result register.
// Beats without last_byte only update the frame state and make no result.
// rst (synchronous, active high) empties both registers and clears the frame.
// A stalled result holds the result register; a last beat waiting behind it
// then holds the input register, which raises in_stall.
module crc8_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [16:0] amount
);

  logic                    full;
  logic [7:0]              byte_q;
  logic                    last_q;
  logic                    out_free;
  logic                    take;
  crc8fc_pkg::frame_snap_t snap;

  // The result register is free when empty or being drained this cycle.
  assign out_free = ~out_valid | ~out_stall;
  // Advance a held beat; a last beat also needs room for its verdict.
  assign take     = full & (~last_q | out_free);

  crc8fc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .take       (take),
    .full       (full),
    .byte_q     (byte_q),
    .last_q     (last_q)
  );

  crc8fc_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .fire   (take),
    .last_q (last_q),
    .byte_q (byte_q),
    .snap   (snap)
  );

  crc8fc_verdict u_verdict (
    .clk       (clk),
    .rst       (rst),
    .load      (take & last_q),
    .snap      (snap),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .amount    (amount)
  );

endmodule

// ===== rtl/crc8fc_in_reg.sv =====
// Input register of the frame checker: holds one byte beat until the tracker takes it.
// Depends on nothing but the port list.
module crc8fc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  logic       take,
  output logic       full,
  output logic [7:0] byte_q,
  output logic       last_q
);

  logic accept;
  logic full_next;

  assign in_stall = full & ~take;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept)    full_next = 1'b1;
    else if (take) full_next = 1'b0;
    else           full_next = full;
  end

  always_ff @(posedge clk) begin
    if (rst) full <= 1'b0;
    else     full <= full_next;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= byte_value;
      last_q <= last_byte;
    end
  end

endmodule

// ===== rtl/crc8fc_tracker.sv =====
// Frame state tracker: byte count, running CRCs and header fields.
// Depends on crc8fc_pkg and the assertion macros header.
`include "crc8_frame_checker_macros.svh"

module crc8fc_tracker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic                   last_q,
  input  logic [7:0]             byte_q,
  output crc8fc_pkg::frame_snap_t snap
);

  logic [15:0] byte_count;
  logic [7:0]  header_crc_run;
  logic [7:0]  body_crc_run;
  logic        start_ok;
  logic        header_crc_ok;
  logic [15:0] frame_length;
  logic [7:0]  body_crc_expected;

  logic [7:0]  header_crc_run_next;
  logic [15:0] pay_index;

  assign pay_index = byte_count - crc8fc_pkg::HDR_BYTES;

  // Build the state as it stands after this beat.
  always_comb begin
    snap.count         = byte_count;
    snap.start_ok      = start_ok;
    snap.header_crc_ok = header_crc_ok;
    snap.frame_length  = frame_length;
    snap.body_crc      = body_crc_run;
    snap.expected_crc  = body_crc_expected;
    header_crc_run_next = header_crc_run;
    if (byte_count != crc8fc_pkg::COUNT_MAX) begin
      if (byte_count == 16'd0 && byte_q != crc8fc_pkg::START_CH0) snap.start_ok = 1'b0;
      if (byte_count == 16'd1 && byte_q != crc8fc_pkg::START_CH1) snap.start_ok = 1'b0;
      if (byte_count == 16'd4) snap.frame_length[7:0]  = byte_q;
      if (byte_count == 16'd5) snap.frame_length[15:8] = byte_q;
      if (byte_count == 16'd6) snap.expected_crc = byte_q;
      if (byte_count < 16'd7)
        header_crc_run_next = crc8fc_pkg::crc_step(header_crc_run, byte_q);
      if (byte_count == 16'd7) snap.header_crc_ok = (byte_q == header_crc_run);
      if (byte_count >= crc8fc_pkg::HDR_BYTES && pay_index < frame_length)
        snap.body_crc = crc8fc_pkg::crc_step(body_crc_run, byte_q);
      snap.count = byte_count + 16'd1;
    end
  end

  // Commit the beat, or drop back to the idle frame on reset or after a verdict.
  always_ff @(posedge clk) begin
    if (rst || (fire && last_q)) begin
      byte_count        <= '0;
      header_crc_run    <= '0;
      body_crc_run      <= '0;
      start_ok          <= 1'b1;
      header_crc_ok     <= 1'b0;
      frame_length      <= '0;
      body_crc_expected <= '0;
    end else if (fire) begin
      byte_count        <= snap.count;
      header_crc_run    <= header_crc_run_next;
      body_crc_run      <= snap.body_crc;
      start_ok          <= snap.start_ok;
      header_crc_ok     <= snap.header_crc_ok;
      frame_length      <= snap.frame_length;
      body_crc_expected <= snap.expected_crc;
    end
  end

  `CRC8FC_ASSERT_NEXT(a_clear_after_verdict, fire && last_q,
    byte_count == 16'd0 && start_ok && !header_crc_ok)
  `CRC8FC_ASSERT_NEXT(a_count_advances,
    fire && !last_q && byte_count != crc8fc_pkg::COUNT_MAX,
    byte_count == 16'($past(byte_count) + 16'd1))
  `CRC8FC_ASSERT_NOW(a_saturated_holds, byte_count == crc8fc_pkg::COUNT_MAX,
    snap.count == crc8fc_pkg::COUNT_MAX)

endmodule

// ===== rtl/crc8fc_verdict.sv =====
// Verdict logic and result register of the frame checker.
// Depends on crc8fc_pkg and the assertion macros header.
`include "crc8_frame_checker_macros.svh"

module crc8fc_verdict (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  crc8fc_pkg::frame_snap_t snap,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [1:0]              status,
  output logic [16:0]             amount
);

  logic [1:0]  status_next;
  logic [16:0] amount_next;
  logic [15:0] pay_seen;
  logic [16:0] len_plus_hdr;
  logic        out_valid_next;

  assign pay_seen     = snap.count - crc8fc_pkg::HDR_BYTES;
  assign len_plus_hdr = {1'b0, snap.frame_length} + {1'b0, crc8fc_pkg::HDR_BYTES};

  always_comb begin
    if (snap.count < crc8fc_pkg::HDR_BYTES) begin
      status_next = crc8fc_pkg::ST_NEED;
      amount_next = {1'b0, crc8fc_pkg::HDR_BYTES - snap.count};
    end else if (!snap.header_crc_ok || !snap.start_ok) begin
      status_next = crc8fc_pkg::ST_HDR_BAD;
      amount_next = 17'd1;
    end else if (snap.frame_length > pay_seen) begin
      status_next = crc8fc_pkg::ST_NEED;
      amount_next = len_plus_hdr - {1'b0, snap.count};
    end else if (snap.body_crc != snap.expected_crc) begin
      status_next = crc8fc_pkg::ST_PAY_BAD;
      amount_next = len_plus_hdr;
    end else begin
      status_next = crc8fc_pkg::ST_VALID;
      amount_next = '0;
    end
  end

  always_comb begin
    if (load)            out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
    else                 out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      amount <= amount_next;
    end
  end

  `CRC8FC_ASSERT_NOW(a_valid_has_no_amount,
    out_valid && status == crc8fc_pkg::ST_VALID, amount == 17'd0)
  `CRC8FC_ASSERT_NOW(a_hdr_bad_skips_one,
    out_valid && status == crc8fc_pkg::ST_HDR_BAD, amount == 17'd1)
  `CRC8FC_ASSERT_NOW(a_load_only_when_free, load, !out_valid || !out_stall)

endmodule
